>>> rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the slab allocator RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sboa_pkg.sv
// ============================================================================
// Slab allocator package
// Widths, codes and shared types for the slab bitmap object allocator.
// ============================================================================
package sboa_pkg;

    // Slab geometry.
    localparam int MAX_SLOTS = 512;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int EFF_W     = SLOT_W + 1;

    // Field widths.
    localparam int ADDR_W    = 48;
    localparam int STRIDE_W  = 21;
    localparam int COUNT_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Product of a slot count and a stride.
    localparam int PROD_W = EFF_W + STRIDE_W;

    // Bitmap memory organization: rows of used bits.
    localparam int ROW_W     = (MAX_SLOTS >= 64) ? 32 : MAX_SLOTS / 2;
    localparam int ROWS      = MAX_SLOTS / ROW_W;
    localparam int ROW_BIT_W = $clog2(ROW_W);
    localparam int ROW_IDX_W = $clog2(ROWS);

    // Stream payload layout.
    localparam int IN_DATA_W    = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + SLOT_W + ADDR_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0]   RST_SLAB_BASE = '0;
    localparam logic [STRIDE_W-1:0] RST_STRIDE    = STRIDE_W'(32);
    localparam logic [COUNT_W-1:0]  RST_COUNT     = COUNT_W'(128);

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_NOT_IN_SLAB  = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    // Serial arithmetic unit operations.
    typedef enum logic {
        SER_MUL = 1'b0,
        SER_DIV = 1'b1
    } t_ser_op;

    typedef struct packed {
        logic    start;
        t_ser_op op;
    } t_ser_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_sts;

endpackage

>>> rtl/sboa_serial.sv
// ============================================================================
// Serial multiply / divide unit
// Bit-serial shift-and-add multiplier and restoring divider sharing one
// accumulator; one multiplier or quotient bit per cycle.
// ============================================================================
module sboa_serial
    import sboa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ser_ctl            i_ctl,
    input  logic [PROD_W-1:0]   i_a,      // multiplier or dividend
    input  logic [STRIDE_W-1:0] i_b,      // multiplicand or divisor
    output t_ser_sts            o_sts,
    output logic [PROD_W-1:0]   o_result
);

    localparam int CNT_W = $clog2(EFF_W + 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(EFF_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SLOT_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    t_ser_op             r_op;
    logic [STRIDE_W-1:0] r_b;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_aux;
    logic [SLOT_W-1:0]   r_q;

    logic [PROD_W-1:0]   s_mul_acc;
    logic [PROD_W-1:0]   s_div_acc;
    logic                s_ge;

    // One step of each operation.
    assign s_mul_acc = (r_acc << 1) + (r_aux[EFF_W-1] ? PROD_W'(r_b) : '0);
    assign s_ge      = (r_acc >= r_aux);
    assign s_div_acc = r_acc - r_aux;

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.op == SER_MUL) ? MUL_LAST : DIV_LAST;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: the multiplier shifts out MSB first, the divisor shifts right.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op <= i_ctl.op;
            r_b  <= i_b;
            r_q  <= '0;
            if (i_ctl.op == SER_MUL) begin
                r_acc <= '0;
                r_aux <= i_a;
            end else begin
                r_acc <= i_a;
                r_aux <= PROD_W'(i_b) << (SLOT_W - 1);
            end
        end else if (r_busy) begin
            if (r_op == SER_MUL) begin
                r_acc <= s_mul_acc;
                r_aux <= r_aux << 1;
            end else begin
                if (s_ge) begin
                    r_acc <= s_div_acc;
                end
                r_q   <= {r_q[SLOT_W-2:0], s_ge};
                r_aux <= r_aux >> 1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = (r_op == SER_DIV) ? PROD_W'(r_q) : r_acc;

endmodule

>>> rtl/slab_bitmap_object_allocator.sv
// ============================================================================
// Slab bitmap object allocator
// Allocates and frees equal-sized objects of one slab using a used bitmap.
// ============================================================================
// Requests arrive on the s_axis channel: tuser[0] selects allocate (0) or
// free (1), tdata carries the address to free. Each request gives exactly
// one result beat on m_axis with status, slot index, object address and the
// number of free slots left. The user must write configuration through
// i_cfg_we, i_cfg_idx and i_cfg_data only while no request is in flight;
// the block itself does not enforce this.
// One request is worked on at a time; the next one can be accepted in the
// cycle in which the result is first offered. A free runs a serial multiply
// for the slab end, a range check, a serial divide by the stride, a bitmap
// row check and the output load; a free that the range check finds outside
// the slab goes straight to the output load. An allocate reads and checks
// one 32-slot row at a time, then runs the serial multiply for the object
// address of the first free slot, or reports a full slab once the scan
// passes the slot count.
// After reset the bitmap memory is cleared one row per cycle, and
// s_axis_tready stays low during that pass. Configuration writes are taken
// at any time. The result sits in an output register; while the receiver
// stalls, the next request is still accepted and worked on, and its result
// waits until the output register is free.
// ============================================================================
module slab_bitmap_object_allocator
    import sboa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ADDR_W-1:0]     i_cfg_data,
    // Request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // address
    input  logic [0:0]            s_axis_tuser,   // op
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status, slot_index,
                                                  // object_address, free_left
);

    `include "assert_macros.svh"

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_SCAN_RD  = 10'b00_0000_0100,
        S_SCAN_CHK = 10'b00_0000_1000,
        S_ADDR_MUL = 10'b00_0001_0000,
        S_END_MUL  = 10'b00_0010_0000,
        S_RANGE    = 10'b00_0100_0000,
        S_DIV      = 10'b00_1000_0000,
        S_FREE_CHK = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } t_state;

    // Lowest set bit of a bitmap row.
    function automatic logic [ROW_BIT_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [ROW_BIT_W-1:0] pos;
        pos = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = ROW_BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Configuration registers.
    logic [ADDR_W-1:0]    r_slab_base;
    logic [STRIDE_W-1:0]  r_stride;
    logic [COUNT_W-1:0]   r_count;

    // Control and working registers.
    t_state               r_state,      n_state;
    logic [ROW_IDX_W:0]   r_row,        n_row;
    logic [EFF_W-1:0]     r_used_total, n_used_total;
    logic [ADDR_W-1:0]    r_addr,       n_addr;
    logic [ADDR_W:0]      r_end,        n_end;
    t_status              r_res_status, n_res_status;
    logic [SLOT_W-1:0]    r_res_slot,   n_res_slot;
    logic [ADDR_W-1:0]    r_res_addr,   n_res_addr;

    // Output register.
    logic                 r_m_valid,    n_m_valid;
    t_status              r_m_status;
    logic [SLOT_W-1:0]    r_m_slot;
    logic [ADDR_W-1:0]    r_m_addr;
    logic [COUNT_W-1:0]   r_m_free;
    logic                 s_emit;

    // Bitmap memory.
    logic [ROW_W-1:0]     r_mem [ROWS];
    logic [ROW_W-1:0]     r_rd_data;
    logic [ROW_IDX_W-1:0] s_rd_idx;
    logic                 s_we;
    logic [ROW_IDX_W-1:0] s_wr_idx;
    logic [ROW_W-1:0]     s_wr_data;

    // Serial arithmetic unit.
    t_ser_ctl             s_ser_ctl;
    t_ser_sts             s_ser_sts;
    logic [PROD_W-1:0]    s_ser_a;
    logic [PROD_W-1:0]    s_ser_result;

    // Derived values.
    logic [EFF_W-1:0]     s_eff_n;
    logic [COUNT_W-1:0]   s_free_left;
    logic [EFF_W-1:0]     s_row_base;
    logic [EFF_W-1:0]     s_room;
    logic [ROW_W-1:0]     s_free_bits;
    logic [ROW_BIT_W-1:0] s_free_pos;
    logic [SLOT_W-1:0]    s_found_slot;
    logic [SLOT_W-1:0]    s_div_slot;
    logic                 s_slot_used;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slab_base <= RST_SLAB_BASE;
            r_stride    <= RST_STRIDE;
            r_count     <= RST_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLAB_BASE:     r_slab_base <= i_cfg_data;
                CFG_OBJECT_STRIDE: r_stride    <= i_cfg_data[STRIDE_W-1:0];
                CFG_OBJECT_COUNT:  r_count     <= i_cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective slot count and free slots left.
    assign s_eff_n     = (int'(r_count) > MAX_SLOTS) ? EFF_W'(MAX_SLOTS) : EFF_W'(r_count);
    assign s_free_left = (s_eff_n > r_used_total) ? COUNT_W'(s_eff_n - r_used_total) : '0;

    // Free slots of the row under scan, limited to slots below the count.
    assign s_row_base = {r_row, {ROW_BIT_W{1'b0}}};
    assign s_room     = s_eff_n - s_row_base;
    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            s_free_bits[j] = ~r_rd_data[j] && (EFF_W'(j) < s_room);
        end
    end
    assign s_free_pos   = lowest_set(s_free_bits);
    assign s_found_slot = {r_row[ROW_IDX_W-1:0], s_free_pos};
    assign s_div_slot   = s_ser_result[SLOT_W-1:0];
    assign s_slot_used  = r_rd_data[r_res_slot[ROW_BIT_W-1:0]];

    // Request sequencer.
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_used_total = r_used_total;
        n_addr       = r_addr;
        n_end        = r_end;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_addr   = r_res_addr;
        s_emit       = 1'b0;
        s_ser_ctl    = '0;
        s_ser_a      = '0;
        s_rd_idx     = r_row[ROW_IDX_W-1:0];
        s_we         = 1'b0;
        s_wr_idx     = r_row[ROW_IDX_W-1:0];
        s_wr_data    = '0;

        case (r_state)
            S_CLEAR: begin
                s_we  = 1'b1;
                n_row = r_row + 1'b1;
                if (r_row[ROW_IDX_W-1:0] == ROW_IDX_W'(ROWS - 1)) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_addr = s_axis_tdata[ADDR_W-1:0];
                    if (s_axis_tuser[0] == OP_ALLOC) begin
                        n_row   = '0;
                        n_state = S_SCAN_RD;
                    end else begin
                        // Slab end needs count times stride first.
                        s_ser_ctl.start = 1'b1;
                        s_ser_ctl.op    = SER_MUL;
                        s_ser_a         = PROD_W'(s_eff_n);
                        n_state         = S_END_MUL;
                    end
                end
            end

            S_SCAN_RD: begin
                if (s_row_base >= s_eff_n) begin
                    n_res_status = ST_FULL;
                    n_res_slot   = '0;
                    n_res_addr   = '0;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (|s_free_bits) begin
                    s_we            = 1'b1;
                    s_wr_data       = r_rd_data | (ROW_W'(1) << s_free_pos);
                    n_res_slot      = s_found_slot;
                    n_used_total    = r_used_total + 1'b1;
                    s_ser_ctl.start = 1'b1;
                    s_ser_ctl.op    = SER_MUL;
                    s_ser_a         = PROD_W'(s_found_slot);
                    n_state         = S_ADDR_MUL;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end

            S_ADDR_MUL: begin
                if (s_ser_sts.done) begin
                    n_res_status = ST_OK;
                    n_res_addr   = r_slab_base + ADDR_W'(s_ser_result);
                    n_state      = S_EMIT;
                end
            end

            S_END_MUL: begin
                if (s_ser_sts.done) begin
                    n_end   = {1'b0, r_slab_base} + (ADDR_W + 1)'(s_ser_result);
                    n_state = S_RANGE;
                end
            end

            S_RANGE: begin
                // A zero stride leaves an empty range and lands here too.
                if ((r_addr < r_slab_base) || ({1'b0, r_addr} >= r_end)) begin
                    n_res_status = ST_NOT_IN_SLAB;
                    n_res_slot   = '0;
                    n_res_addr   = '0;
                    n_state      = S_EMIT;
                end else begin
                    s_ser_ctl.start = 1'b1;
                    s_ser_ctl.op    = SER_DIV;
                    s_ser_a         = PROD_W'(r_addr - r_slab_base);
                    n_state         = S_DIV;
                end
            end

            S_DIV: begin
                if (s_ser_sts.done) begin
                    n_res_addr = '0;
                    if (EFF_W'(s_div_slot) >= s_eff_n) begin
                        n_res_status = ST_NOT_IN_SLAB;
                        n_res_slot   = '0;
                        n_state      = S_EMIT;
                    end else begin
                        n_res_slot = s_div_slot;
                        s_rd_idx   = s_div_slot[SLOT_W-1:ROW_BIT_W];
                        n_state    = S_FREE_CHK;
                    end
                end
            end

            S_FREE_CHK: begin
                if (!s_slot_used) begin
                    n_res_status = ST_ALREADY_FREE;
                end else begin
                    n_res_status = ST_OK;
                    s_we         = 1'b1;
                    s_wr_idx     = r_res_slot[SLOT_W-1:ROW_BIT_W];
                    s_wr_data    = r_rd_data & ~(ROW_W'(1) << r_res_slot[ROW_BIT_W-1:0]);
                    if (r_used_total != '0) begin
                        n_used_total = r_used_total - 1'b1;
                    end
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    s_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_row   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_row        <= '0;
            r_used_total <= '0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_used_total <= n_used_total;
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_end        <= n_end;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_addr   <= n_res_addr;
    end

    // Bitmap memory: one row read and one row written per cycle.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wr_idx] <= s_wr_data;
        end
        r_rd_data <= r_mem[s_rd_idx];
    end

    // Output register.
    always_comb begin
        n_m_valid = r_m_valid;
        if (s_emit) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_m_status <= r_res_status;
            r_m_slot   <= r_res_slot;
            r_m_addr   <= r_res_addr;
            r_m_free   <= s_free_left;
        end
    end

    sboa_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ser_ctl),
        .i_a      (s_ser_a),
        .i_b      (r_stride),
        .o_sts    (s_ser_sts),
        .o_result (s_ser_result)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_m_free, r_m_addr, r_m_slot, r_m_status};

    // Checks on the sequencer and its arithmetic unit.
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while another is in flight")
    `ASSERT_IMPLIES(a_start_idle_unit, i_clk, i_rst_n, s_ser_ctl.start, !s_ser_sts.busy, "serial unit started while busy")
    `ASSERT_IMPLIES(a_done_awaited, i_clk, i_rst_n, s_ser_sts.done, (r_state == S_ADDR_MUL) || (r_state == S_END_MUL) || (r_state == S_DIV), "serial result not awaited")
    `ASSERT_IMPLIES(a_error_no_addr, i_clk, i_rst_n, r_m_valid && (r_m_status != ST_OK), r_m_addr == '0, "error result carries an address")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Slab allocator testbench
// Sends allocate and free requests to the slab bitmap object allocator and
// compares every result beat with a behavioral prediction of the slab kept
// in the bench: the used bitmap, the used count and the three registers.
// A short directed part hits the edge cases. Random parts with changing
// slab geometry and random stalls on both streams follow.
// ============================================================================
module tb
    import sboa_pkg::*;
();

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // One result beat, unpacked.
    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot;
        logic [ADDR_W-1:0]     obj_addr;
        logic [COUNT_W-1:0]    free_left;
    } t_slab_result;

    // Block ports.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = CFG_SLAB_BASE;
    logic [ADDR_W-1:0]     i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // address
    logic [0:0]            s_axis_tuser  = OP_ALLOC;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // status, slot_index, object_address,
                                           // free_left

    // Shadow of the slab held by the bench.
    logic [ADDR_W-1:0]     slab_base;
    logic [STRIDE_W-1:0]   obj_stride;
    logic [COUNT_W-1:0]    obj_count;
    bit [MAX_SLOTS-1:0]    used_map;
    int unsigned           used_total;

    // Results owed by the block, oldest first.
    t_slab_result          slab_results_due[$];

    // Run bookkeeping.
    int unsigned           fail_count;
    int unsigned           alloc_sent;
    int unsigned           free_sent;
    int unsigned           status_seen[4];
    int unsigned           quiet_cycles;
    bit                    tx_jitter = 1'b1;
    bit                    rx_jitter = 1'b1;
    int unsigned           hold_requests;

    slab_bitmap_object_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Slab prediction
    // ------------------------------------------------------------------------

    // Slot count in effect: the register value is capped at the bitmap size.
    function automatic int unsigned usable_slots();
        return (obj_count > MAX_SLOTS) ? MAX_SLOTS : obj_count;
    endfunction

    // First address past the slab, kept wider than the address bus.
    function automatic logic [63:0] slab_end();
        return 64'(slab_base) + 64'(usable_slots()) * 64'(obj_stride);
    endfunction

    // Applies one request to the shadow slab and returns the result it owes.
    function automatic t_slab_result predict_slab_request(logic op, logic [ADDR_W-1:0] addr);
        t_slab_result r;
        int unsigned  n;
        logic [63:0]  slot;
        bit           found;
        n = usable_slots();
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        if (op == OP_ALLOC) begin
            // Lowest free slot below the slot count.
            for (int i = 0; i < n; i++) begin
                if (!used_map[i]) begin
                    used_map[i] = 1'b1;
                    used_total++;
                    r.slot     = SLOT_W'(i);
                    r.obj_addr = ADDR_W'(64'(slab_base) + 64'(i) * 64'(obj_stride));
                    found      = 1'b1;
                    break;
                end
            end
            if (!found)
                r.status = ST_FULL;
        end else if (obj_stride == 0 || addr < slab_base || 64'(addr) >= slab_end()) begin
            r.status = ST_NOT_IN_SLAB;
        end else begin
            slot = (64'(addr) - 64'(slab_base)) / 64'(obj_stride);
            if (slot >= n) begin
                r.status = ST_NOT_IN_SLAB;
            end else if (!used_map[slot]) begin
                r.status = ST_ALREADY_FREE;
                r.slot   = SLOT_W'(slot);
            end else begin
                used_map[slot] = 1'b0;
                if (used_total > 0)
                    used_total--;
                r.slot = SLOT_W'(slot);
            end
        end
        r.free_left = COUNT_W'((n > used_total) ? n - used_total : 0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Sends one request beat and records what it should produce. Valid stays
    // high after the beat so back-to-back requests need no extra edge.
    task automatic send_req(logic op, logic [ADDR_W-1:0] addr);
        t_slab_result r;
        if (tx_jitter && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 70);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= addr;
        s_axis_tuser[0] <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        r = predict_slab_request(op, addr);
        slab_results_due.push_back(r);
        status_seen[r.status]++;
        if (op == OP_ALLOC)
            alloc_sent++;
        else
            free_sent++;
    endtask

    // Stops offering requests and waits until every owed result has arrived.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (slab_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers with the block idle. Bits above a register's
    // width carry junk, which the block must drop.
    task automatic set_config(logic [ADDR_W-1:0] base, logic [STRIDE_W-1:0] stride,
                              logic [COUNT_W-1:0] count);
        logic [ADDR_W-1:0] junk;
        junk = ADDR_W'({$urandom, $urandom});
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SLAB_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OBJECT_STRIDE;
        i_cfg_data <= {junk[ADDR_W-1:STRIDE_W], stride};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OBJECT_COUNT;
        i_cfg_data <= {junk[ADDR_W-1:COUNT_W], count};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        slab_base  = base;
        obj_stride = stride;
        obj_count  = count;
    endtask

    // Address inside the slab, on a used slot when one is found quickly.
    function automatic logic [ADDR_W-1:0] object_in_slab(bit want_used);
        int unsigned n;
        int unsigned slot;
        logic [63:0] offs;
        n    = usable_slots();
        slot = (n == 0) ? 0 : $urandom_range(n - 1);
        if (want_used && n != 0)
            for (int t = 0; t < 16 && !used_map[slot]; t++)
                slot = $urandom_range(n - 1);
        offs = 0;
        if (obj_stride > 1 && $urandom_range(1))
            offs = $urandom_range(1) ? obj_stride - 1 : $urandom_range(obj_stride - 1);
        return ADDR_W'(64'(slab_base) + 64'(slot) * 64'(obj_stride) + offs);
    endfunction

    // Address around or far from the slab edges.
    function automatic logic [ADDR_W-1:0] stray_address();
        case ($urandom_range(4))
            0:       return ADDR_W'({$urandom, $urandom});
            1:       return slab_base - ADDR_W'(1 + $urandom_range(3));
            2:       return ADDR_W'(slab_end() + $urandom_range(3));
            3:       return ADDR_W'(slab_end() - 1);
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    // Random requests: mostly allocations and frees of live objects, the rest
    // double frees and addresses around or far from the slab.
    task automatic run_random(int unsigned items, int unsigned alloc_pct);
        int unsigned roll;
        int unsigned rest;
        repeat (items) begin
            roll = $urandom_range(99);
            rest = 100 - alloc_pct;
            if (roll < alloc_pct)
                send_req(OP_ALLOC, ADDR_W'({$urandom, $urandom}));
            else if (roll < alloc_pct + rest * 70 / 100)
                send_req(OP_FREE, object_in_slab(1'b1));
            else if (roll < alloc_pct + rest * 85 / 100)
                send_req(OP_FREE, object_in_slab(1'b0));
            else
                send_req(OP_FREE, stray_address());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Receiver readiness: random stalls, plus long hold-offs on request.
    always @(posedge i_clk) begin : result_ready
        int unsigned hold_left;
        int unsigned holds_done;
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(rx_jitter && $urandom_range(99) < 10);
        end
    end

    // Compares each result beat with the oldest owed result.
    always @(posedge i_clk) begin : check_results
        t_slab_result got;
        t_slab_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status    = t_status'(m_axis_tdata[STATUS_W-1:0]);
            got.slot      = m_axis_tdata[STATUS_W +: SLOT_W];
            got.obj_addr  = m_axis_tdata[STATUS_W + SLOT_W +: ADDR_W];
            got.free_left = m_axis_tdata[STATUS_W + SLOT_W + ADDR_W +: COUNT_W];
            if (slab_results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing owed: status %0d slot %0d",
                             $realtime, got.status, got.slot);
            end else begin
                want = slab_results_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch: expected status %0d slot %0d addr %h ",
                                  "free %0d, got status %0d slot %0d addr %h free %0d"},
                                 $realtime, want.status, want.slot, want.obj_addr,
                                 want.free_left, got.status, got.slot, got.obj_addr,
                                 got.free_left);
                end
            end
        end
    end

    // Ends the run when no beat moves on either stream for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge cases, starting from the reset geometry.
    task automatic test_directed();
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '1);                  // address ignored on allocate
        send_req(OP_FREE, ADDR_W'(32 + 5));      // inside slot 1, off its start
        send_req(OP_FREE, ADDR_W'(32));          // double free
        send_req(OP_FREE, ADDR_W'(128 * 32));    // first address past the slab
        send_req(OP_FREE, '1);
        send_req(OP_FREE, ADDR_W'(128 * 32 - 1)); // last byte, slot never used
        // Top of the address space: the end lies past 48 bits, the object
        // address wraps, and the count saturates.
        set_config(ADDR_W'(48'hFFFF_FFFF_FF00), '1, '1);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, '1);
        send_req(OP_FREE, ADDR_W'(48'hFFFF_FFFF_FEFF));
        send_req(OP_FREE, '0);
        // Zero stride: allocation still works, nothing can be freed.
        set_config(ADDR_W'(48'h1234_5678_9ABC), '0, COUNT_W'(4));
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, ADDR_W'(48'h1234_5678_9ABC));
        // Empty slab.
        set_config('0, STRIDE_W'(4), '0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, '0);
        // Count shrunk below the slots in use.
        set_config('0, STRIDE_W'(4), COUNT_W'(2));
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, ADDR_W'(4));
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, ADDR_W'(8));
    endtask

    // Many small slabs that fill up often.
    task automatic test_small_slabs();
        logic [STRIDE_W-1:0] stride;
        repeat (6) begin
            case ($urandom_range(3))
                0:       stride = STRIDE_W'(4);
                1:       stride = STRIDE_W'($urandom_range(1, 3));
                default: stride = STRIDE_W'($urandom_range(4, 300));
            endcase
            set_config($urandom_range(1) ? ADDR_W'({$urandom, $urandom}) : '0, stride,
                       COUNT_W'($urandom_range(1, 16)));
            run_random(40, 50);
        end
    endtask

    // Zero stride and zero count.
    task automatic test_degenerate_slabs();
        set_config(ADDR_W'({$urandom, $urandom}), '0, COUNT_W'($urandom_range(1, 32)));
        run_random(40, 60);
        set_config(ADDR_W'({$urandom, $urandom}), STRIDE_W'(64), '0);
        run_random(20, 50);
    endtask

    // Slabs at the top of the address space with the largest strides.
    task automatic test_high_slabs();
        set_config('1 - ADDR_W'($urandom_range(4095)), STRIDE_W'(1048576), COUNT_W'(512));
        run_random(60, 70);
        set_config('1, '1, COUNT_W'(512));
        run_random(40, 60);
    endtask

    // Counts above the bitmap size.
    task automatic test_saturated_count();
        set_config(ADDR_W'({$urandom, $urandom}), STRIDE_W'($urandom_range(4, 64)), '1);
        run_random(70, 65);
        set_config('0, STRIDE_W'($urandom_range(4, 64)), COUNT_W'(513));
        run_random(50, 55);
    endtask

    // Grows a slab, shrinks it below the slots in use, then grows it again.
    task automatic test_shrunk_count();
        set_config('0, STRIDE_W'(16), COUNT_W'(64));
        run_random(80, 80);
        set_config('0, STRIDE_W'(16), COUNT_W'(8));
        run_random(40, 40);
        set_config('0, STRIDE_W'(16), COUNT_W'(200));
        run_random(40, 50);
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        set_config(ADDR_W'(48'h1000), STRIDE_W'(64), COUNT_W'(32));
        tx_jitter = 1'b0;
        hold_requests++;
        run_random(16, 60);
        tx_jitter = 1'b1;
        settle();
    endtask

    // A stretch with no idling on either side.
    task automatic test_steady_stream();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        run_random(120, 50);
        settle();
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    // Random geometry of every kind, including the register extremes.
    task automatic test_mixed();
        logic [ADDR_W-1:0]   base;
        logic [STRIDE_W-1:0] stride;
        logic [COUNT_W-1:0]  count;
        repeat (5) begin
            case ($urandom_range(2))
                0:       base = '0;
                1:       base = '1;
                default: base = ADDR_W'({$urandom, $urandom});
            endcase
            case ($urandom_range(5))
                0:       stride = STRIDE_W'(4);
                1:       stride = STRIDE_W'(1048576);
                2:       stride = '1;
                3:       stride = STRIDE_W'($urandom_range(4, 100));
                4:       stride = STRIDE_W'($urandom);
                default: stride = '0;
            endcase
            case ($urandom_range(2))
                0:       count = COUNT_W'(1);
                1:       count = COUNT_W'(512);
                default: count = COUNT_W'($urandom_range(0, 1023));
            endcase
            set_config(base, stride, count);
            run_random(30, 50);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        slab_base  = RST_SLAB_BASE;
        obj_stride = RST_STRIDE;
        obj_count  = RST_COUNT;
        used_map   = '0;
        used_total = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_small_slabs();
        test_degenerate_slabs();
        test_high_slabs();
        test_saturated_count();
        test_shrunk_count();
        test_backpressure();
        test_steady_stream();
        test_mixed();

        settle();
        repeat (50) @(posedge i_clk);
        if (slab_results_due.size() != 0)
            fail_count++;

        $display("Covered %0d requests: %0d allocate, %0d free, %0d errors counted",
                 alloc_sent + free_sent, alloc_sent, free_sent, fail_count);
        $display("Statuses: ok %0d, full %0d, outside slab %0d, double free %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_IN_SLAB],
                 status_seen[ST_ALREADY_FREE]);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
